// ===== hdl/fourier_potential_tidal_scale_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef FOURIER_POTENTIAL_TIDAL_SCALE_UNIT_MACROS_SVH
`define FOURIER_POTENTIAL_TIDAL_SCALE_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define FPTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define FPTS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/fpts_pkg.sv =====
package fpts_pkg;

   // grid and field widths
   localparam int MAX_GRID = 1024;
   localparam int GS_W     = 11;
   localparam int IDX_W    = 10;
   localparam int STEP_W   = 32;
   localparam int MODE_W   = 3;
   localparam int VAL_W    = 32;
   localparam int CSR_IX_W = 3;

   // datapath widths
   localparam int NM_W   = 10;             // |n| <= 1023
   localparam int KM_W   = NM_W + STEP_W;  // |n| * step, Q.28
   localparam int HALF_W = KM_W / 2;       // split for squaring
   localparam int PP_W   = 2 * HALF_W;     // one partial product
   localparam int SQ_W   = 2 * KM_W;       // one square, Q.56
   localparam int K2_W   = SQ_W + 2;       // sum of three squares
   localparam int CH_W   = 29;             // numerator base chunk
   localparam int NB_W   = 3 * CH_W;       // numerator base
   localparam int CP_W   = CH_W + VAL_W;   // chunk * value
   localparam int NUM_W  = SQ_W + VAL_W;   // base * |value|
   localparam int N_W    = NUM_W + 2;      // 2*num + den
   localparam int D_W    = K2_W + 2;       // 2*den, with headroom
   localparam int Q_W    = VAL_W + 1;      // quotient bits kept
   localparam int POT_SHIFT = 56;          // 1.0 in Q.56

   // pipeline positions
   localparam int ST_DIV  = 8;             // divider setup stage
   localparam int NUM_ST  = ST_DIV + Q_W + 2;

   // register indexes
   typedef enum logic [CSR_IX_W-1:0] {
      CSR_GRID_X = 3'd0,
      CSR_GRID_Y = 3'd1,
      CSR_GRID_Z = 3'd2,
      CSR_STEP_X = 3'd3,
      CSR_STEP_Y = 3'd4,
      CSR_STEP_Z = 3'd5,
      CSR_MODE   = 3'd6
   } csr_index_type;

   // scale modes
   localparam logic [MODE_W-1:0] MODE_POT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_XX  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_XY  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_XZ  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_YY  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_YZ  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_ZZ  = 3'd6;
   localparam logic [MODE_W-1:0] MODE_BAD = 3'd7;

   localparam logic [VAL_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] NEG_LIMIT = 32'h8000_0000;

endpackage

// ===== hdl/fourier_potential_tidal_scale_unit.sv =====
// Fourier-space potential / tidal scaling of one half-complex grid bin.
// Request channel: req_valid / req_stall with bin indices and a Q16.16
// complex value. A request is taken at a clock edge with req_valid high and
// req_stall low. Response channel: rsp_valid / rsp_stall with the scaled
// value and a saturation flag, one response per request, in order.
// Register port: csr_valid / csr_ready with index and data; csr_ready is
// always high. Write registers only while no request is in flight.
// Throughput: one bin per cycle while req_stall is low. The restoring
// divider gives one quotient bit per stage for each of the two parts.
// When the receiver stalls, the pipeline keeps moving until the skid
// register behind the output register fills; only then is req_stall
// raised, so one more request is taken behind a waiting response.
// Reset (synchronous, active high) empties the pipeline and loads the
// register defaults: 256-cell grids, unit steps, potential mode.
module fourier_potential_tidal_scale_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [fpts_pkg::IDX_W-1:0]  req_x_index,
   input  logic [fpts_pkg::IDX_W-1:0]  req_y_index,
   input  logic [fpts_pkg::IDX_W-1:0]  req_z_index,
   input  logic signed [fpts_pkg::VAL_W-1:0] req_re_in,
   input  logic signed [fpts_pkg::VAL_W-1:0] req_im_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [fpts_pkg::VAL_W-1:0] rsp_re_out,
   output logic signed [fpts_pkg::VAL_W-1:0] rsp_im_out,
   output logic                        rsp_saturated,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [fpts_pkg::CSR_IX_W-1:0] csr_index,
   input  logic [fpts_pkg::STEP_W-1:0] csr_wdata
);

   // ---------------------------------------------------------------
   // helpers
   function automatic logic [fpts_pkg::GS_W-1:0] clamp_size(
      input logic [fpts_pkg::GS_W-1:0] n);
      logic [fpts_pkg::GS_W-1:0] r;
      if (n < fpts_pkg::GS_W'(2)) r = fpts_pkg::GS_W'(2);
      else if (n > fpts_pkg::GS_W'(fpts_pkg::MAX_GRID)) r = fpts_pkg::GS_W'(fpts_pkg::MAX_GRID);
      else r = n;
      return r;
   endfunction

   // returns {negative, magnitude}
   function automatic logic [fpts_pkg::NM_W:0] fold_xy(
      input logic [fpts_pkg::IDX_W-1:0] idx, input logic [fpts_pkg::GS_W-1:0] n);
      logic [fpts_pkg::GS_W-1:0] ix;
      logic [fpts_pkg::NM_W:0]   r;
      ix = fpts_pkg::GS_W'(idx);
      if ({idx, 1'b0} < n) r = {1'b0, idx};
      else if (ix >= n) r = {1'b0, fpts_pkg::NM_W'(ix - n)};
      else r = {1'b1, fpts_pkg::NM_W'(n - ix)};
      return r;
   endfunction

   function automatic logic [fpts_pkg::NM_W:0] fold_z(
      input logic [fpts_pkg::IDX_W-1:0] idx, input logic [fpts_pkg::GS_W-1:0] n);
      logic [fpts_pkg::NM_W:0] r;
      if (!n[0] && fpts_pkg::GS_W'(idx) == (n >> 1))
         r = {1'b1, fpts_pkg::NM_W'(n >> 1)};
      else
         r = {1'b0, idx};
      return r;
   endfunction

   function automatic logic [1:0] comp_a(input logic [fpts_pkg::MODE_W-1:0] m);
      logic [1:0] r;
      case (m) inside
         fpts_pkg::MODE_YY, fpts_pkg::MODE_YZ: r = 2'd1;
         fpts_pkg::MODE_ZZ:                    r = 2'd2;
         default:                              r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] comp_b(input logic [fpts_pkg::MODE_W-1:0] m);
      logic [1:0] r;
      case (m) inside
         fpts_pkg::MODE_XY, fpts_pkg::MODE_YY:                    r = 2'd1;
         fpts_pkg::MODE_XZ, fpts_pkg::MODE_YZ, fpts_pkg::MODE_ZZ: r = 2'd2;
         default:                                                 r = 2'd0;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------
   // configuration registers
   logic [fpts_pkg::GS_W-1:0]   gs_ff [3];
   logic [fpts_pkg::STEP_W-1:0] step_ff [3];
   logic [fpts_pkg::MODE_W-1:0] mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gs_ff[0]   <= fpts_pkg::GS_W'(256);
         gs_ff[1]   <= fpts_pkg::GS_W'(256);
         gs_ff[2]   <= fpts_pkg::GS_W'(256);
         step_ff[0] <= 32'h1000_0000;
         step_ff[1] <= 32'h1000_0000;
         step_ff[2] <= 32'h1000_0000;
         mode_ff    <= fpts_pkg::MODE_POT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fpts_pkg::CSR_GRID_X: gs_ff[0]   <= csr_wdata[fpts_pkg::GS_W-1:0];
            fpts_pkg::CSR_GRID_Y: gs_ff[1]   <= csr_wdata[fpts_pkg::GS_W-1:0];
            fpts_pkg::CSR_GRID_Z: gs_ff[2]   <= csr_wdata[fpts_pkg::GS_W-1:0];
            fpts_pkg::CSR_STEP_X: step_ff[0] <= csr_wdata;
            fpts_pkg::CSR_STEP_Y: step_ff[1] <= csr_wdata;
            fpts_pkg::CSR_STEP_Z: step_ff[2] <= csr_wdata;
            fpts_pkg::CSR_MODE:   mode_ff    <= csr_wdata[fpts_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // pipeline control: all stages move together unless the skid is full
   logic en;
   logic v_ff [fpts_pkg::NUM_ST];
   logic sk_v_ff, o_v_ff, take;

   assign en        = !sk_v_ff;
   assign req_stall = sk_v_ff;
   assign take      = o_v_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < fpts_pkg::NUM_ST; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req_valid;
         for (int k = 1; k < fpts_pkg::NUM_ST; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   // ---------------------------------------------------------------
   // stage 1: fold indices, split value signs
   logic [fpts_pkg::NM_W-1:0]   s1_nm_ff [3];
   logic                        s1_kn_ff [3];
   logic [fpts_pkg::VAL_W-1:0]  s1_vm_ff [2];
   logic                        s1_vn_ff [2];
   logic [fpts_pkg::MODE_W-1:0] s1_mode_ff;
   logic [fpts_pkg::NM_W:0]     f_in [3];
   logic [fpts_pkg::VAL_W-1:0]  raw_in [2];

   always_comb begin
      f_in[0]   = fold_xy(req_x_index, clamp_size(gs_ff[0]));
      f_in[1]   = fold_xy(req_y_index, clamp_size(gs_ff[1]));
      f_in[2]   = fold_z(req_z_index, clamp_size(gs_ff[2]));
      raw_in[0] = req_re_in;
      raw_in[1] = req_im_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s1_nm_ff[i] <= f_in[i][fpts_pkg::NM_W-1:0];
            s1_kn_ff[i] <= f_in[i][fpts_pkg::NM_W];
         end
         for (int j = 0; j < 2; j++) begin
            s1_vn_ff[j] <= raw_in[j][fpts_pkg::VAL_W-1];
            s1_vm_ff[j] <= raw_in[j][fpts_pkg::VAL_W-1] ? (~raw_in[j] + 1'b1) : raw_in[j];
         end
         s1_mode_ff <= mode_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: wavevector magnitudes |n| * step
   logic [fpts_pkg::KM_W-1:0]   s2_km_ff [3];
   logic                        s2_kn_ff [3];
   logic [fpts_pkg::VAL_W-1:0]  s2_vm_ff [2];
   logic                        s2_vn_ff [2];
   logic [fpts_pkg::MODE_W-1:0] s2_mode_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s2_km_ff[i] <= fpts_pkg::KM_W'(s1_nm_ff[i]) * fpts_pkg::KM_W'(step_ff[i]);
            s2_kn_ff[i] <= s1_kn_ff[i];
         end
         s2_vm_ff   <= s1_vm_ff;
         s2_vn_ff   <= s1_vn_ff;
         s2_mode_ff <= s1_mode_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: half-width partial products for squares and ka*kb
   logic [fpts_pkg::PP_W-1:0]  s3_hh_ff [3], s3_hl_ff [3], s3_ll_ff [3];
   logic [fpts_pkg::PP_W-1:0]  s3_thh_ff, s3_thl_ff, s3_tlh_ff, s3_tll_ff;
   logic                       s3_pot_ff, s3_bad_ff, s3_flip_ff;
   logic [fpts_pkg::VAL_W-1:0] s3_vm_ff [2];
   logic                       s3_vn_ff [2];
   logic [fpts_pkg::KM_W-1:0]  ka, kb;
   logic [1:0]                 ax_a, ax_b;

   always_comb begin
      ax_a = comp_a(s2_mode_ff);
      ax_b = comp_b(s2_mode_ff);
      ka   = s2_km_ff[ax_a];
      kb   = s2_km_ff[ax_b];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s3_hh_ff[i] <= fpts_pkg::PP_W'(s2_km_ff[i][fpts_pkg::KM_W-1:fpts_pkg::HALF_W])
                         * fpts_pkg::PP_W'(s2_km_ff[i][fpts_pkg::KM_W-1:fpts_pkg::HALF_W]);
            s3_hl_ff[i] <= fpts_pkg::PP_W'(s2_km_ff[i][fpts_pkg::KM_W-1:fpts_pkg::HALF_W])
                         * fpts_pkg::PP_W'(s2_km_ff[i][fpts_pkg::HALF_W-1:0]);
            s3_ll_ff[i] <= fpts_pkg::PP_W'(s2_km_ff[i][fpts_pkg::HALF_W-1:0])
                         * fpts_pkg::PP_W'(s2_km_ff[i][fpts_pkg::HALF_W-1:0]);
         end
         s3_thh_ff <= fpts_pkg::PP_W'(ka[fpts_pkg::KM_W-1:fpts_pkg::HALF_W])
                    * fpts_pkg::PP_W'(kb[fpts_pkg::KM_W-1:fpts_pkg::HALF_W]);
         s3_thl_ff <= fpts_pkg::PP_W'(ka[fpts_pkg::KM_W-1:fpts_pkg::HALF_W])
                    * fpts_pkg::PP_W'(kb[fpts_pkg::HALF_W-1:0]);
         s3_tlh_ff <= fpts_pkg::PP_W'(ka[fpts_pkg::HALF_W-1:0])
                    * fpts_pkg::PP_W'(kb[fpts_pkg::KM_W-1:fpts_pkg::HALF_W]);
         s3_tll_ff <= fpts_pkg::PP_W'(ka[fpts_pkg::HALF_W-1:0])
                    * fpts_pkg::PP_W'(kb[fpts_pkg::HALF_W-1:0]);
         s3_pot_ff  <= (s2_mode_ff == fpts_pkg::MODE_POT);
         s3_bad_ff  <= (s2_mode_ff == fpts_pkg::MODE_BAD);
         s3_flip_ff <= (s2_mode_ff == fpts_pkg::MODE_POT) ? 1'b1
                     : (s2_kn_ff[ax_a] ^ s2_kn_ff[ax_b]);
         s3_vm_ff   <= s2_vm_ff;
         s3_vn_ff   <= s2_vn_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 4: assemble squares and numerator base
   logic [fpts_pkg::SQ_W-1:0]  s4_sq_ff [3];
   logic [fpts_pkg::NB_W-1:0]  s4_nb_ff;
   logic                       s4_bad_ff, s4_flip_ff;
   logic [fpts_pkg::VAL_W-1:0] s4_vm_ff [2];
   logic                       s4_vn_ff [2];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s4_sq_ff[i] <= (fpts_pkg::SQ_W'(s3_hh_ff[i]) << (2 * fpts_pkg::HALF_W))
                         + (fpts_pkg::SQ_W'(s3_hl_ff[i]) << (fpts_pkg::HALF_W + 1))
                         + fpts_pkg::SQ_W'(s3_ll_ff[i]);
         end
         if (s3_pot_ff)
            s4_nb_ff <= fpts_pkg::NB_W'(1) << fpts_pkg::POT_SHIFT;
         else
            s4_nb_ff <= (fpts_pkg::NB_W'(s3_thh_ff) << (2 * fpts_pkg::HALF_W))
                      + ((fpts_pkg::NB_W'(s3_thl_ff) + fpts_pkg::NB_W'(s3_tlh_ff))
                         << fpts_pkg::HALF_W)
                      + fpts_pkg::NB_W'(s3_tll_ff);
         s4_bad_ff  <= s3_bad_ff;
         s4_flip_ff <= s3_flip_ff;
         s4_vm_ff   <= s3_vm_ff;
         s4_vn_ff   <= s3_vn_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 5: k^2, kill flag, result signs
   logic [fpts_pkg::K2_W-1:0]  s5_k2_ff;
   logic [fpts_pkg::NB_W-1:0]  s5_nb_ff;
   logic                       s5_kill_ff;
   logic                       s5_neg_ff [2];
   logic [fpts_pkg::VAL_W-1:0] s5_vm_ff [2];

   always_ff @(posedge clock) begin
      if (en) begin
         s5_k2_ff   <= fpts_pkg::K2_W'(s4_sq_ff[0]) + fpts_pkg::K2_W'(s4_sq_ff[1])
                     + fpts_pkg::K2_W'(s4_sq_ff[2]);
         s5_kill_ff <= s4_bad_ff || ((s4_sq_ff[0] | s4_sq_ff[1] | s4_sq_ff[2]) == '0);
         s5_nb_ff   <= s4_nb_ff;
         for (int j = 0; j < 2; j++) s5_neg_ff[j] <= s4_vn_ff[j] ^ s4_flip_ff;
         s5_vm_ff   <= s4_vm_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 6: numerator partial products, chunk by value
   logic [fpts_pkg::CP_W-1:0]  s6_p_ff [2][3];
   logic [fpts_pkg::K2_W-1:0]  s6_k2_ff;
   logic                       s6_kill_ff;
   logic                       s6_neg_ff [2];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 2; j++) begin
            for (int c = 0; c < 3; c++) begin
               s6_p_ff[j][c] <= fpts_pkg::CP_W'(s5_nb_ff[c*fpts_pkg::CH_W +: fpts_pkg::CH_W])
                              * fpts_pkg::CP_W'(s5_vm_ff[j]);
            end
         end
         s6_k2_ff   <= s5_k2_ff;
         s6_kill_ff <= s5_kill_ff;
         s6_neg_ff  <= s5_neg_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 7: full numerators
   logic [fpts_pkg::NUM_W-1:0] s7_num_ff [2];
   logic [fpts_pkg::K2_W-1:0]  s7_k2_ff;
   logic                       s7_kill_ff;
   logic                       s7_neg_ff [2];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 2; j++) begin
            s7_num_ff[j] <= (fpts_pkg::NUM_W'(s6_p_ff[j][2]) << (2 * fpts_pkg::CH_W))
                          + (fpts_pkg::NUM_W'(s6_p_ff[j][1]) << fpts_pkg::CH_W)
                          + fpts_pkg::NUM_W'(s6_p_ff[j][0]);
         end
         s7_k2_ff   <= s6_k2_ff;
         s7_kill_ff <= s6_kill_ff;
         s7_neg_ff  <= s6_neg_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 8: rounding offset, 2*num + den over 2*den
   logic [fpts_pkg::N_W-1:0] s8_n_ff [2];
   logic [fpts_pkg::D_W-1:0] s8_d_ff;
   logic                     s8_kill_ff;
   logic                     s8_neg_ff [2];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 2; j++) begin
            s8_n_ff[j] <= (fpts_pkg::N_W'(s7_num_ff[j]) << 1) + fpts_pkg::N_W'(s7_k2_ff);
         end
         s8_d_ff    <= fpts_pkg::D_W'(s7_k2_ff) << 1;
         s8_kill_ff <= s7_kill_ff;
         s8_neg_ff  <= s7_neg_ff;
      end
   end

   // ---------------------------------------------------------------
   // divider: setup (overflow test on upper bits), then one bit per stage
   logic [fpts_pkg::D_W-1:0] dv_d_ff  [fpts_pkg::Q_W+1];
   logic                     dv_kill_ff [fpts_pkg::Q_W+1];
   logic [fpts_pkg::D_W-1:0] dv_r_ff  [2][fpts_pkg::Q_W+1];
   logic [fpts_pkg::Q_W-1:0] dv_lo_ff [2][fpts_pkg::Q_W+1];
   logic [fpts_pkg::Q_W-1:0] dv_q_ff  [2][fpts_pkg::Q_W+1];
   logic                     dv_ovf_ff [2][fpts_pkg::Q_W+1];
   logic                     dv_neg_ff [2][fpts_pkg::Q_W+1];

   always_ff @(posedge clock) begin
      if (en) begin
         dv_d_ff[0]    <= s8_d_ff;
         dv_kill_ff[0] <= s8_kill_ff;
         for (int j = 0; j < 2; j++) begin
            dv_r_ff[j][0]   <= fpts_pkg::D_W'(s8_n_ff[j][fpts_pkg::N_W-1:fpts_pkg::Q_W]);
            dv_ovf_ff[j][0] <= fpts_pkg::D_W'(s8_n_ff[j][fpts_pkg::N_W-1:fpts_pkg::Q_W])
                               >= s8_d_ff;
            dv_lo_ff[j][0]  <= s8_n_ff[j][fpts_pkg::Q_W-1:0];
            dv_q_ff[j][0]   <= '0;
            dv_neg_ff[j][0] <= s8_neg_ff[j];
         end
      end
   end

   for (genvar t = 0; t < fpts_pkg::Q_W; t++) begin : g_div
      logic [fpts_pkg::D_W:0] rs_in [2];
      logic                   ge_in [2];

      // shift in the next numerator bit and try a subtract
      always_comb begin
         for (int j = 0; j < 2; j++) begin
            rs_in[j] = {dv_r_ff[j][t], dv_lo_ff[j][t][fpts_pkg::Q_W-1]};
            ge_in[j] = rs_in[j] >= {1'b0, dv_d_ff[t]};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_d_ff[t+1]    <= dv_d_ff[t];
            dv_kill_ff[t+1] <= dv_kill_ff[t];
            for (int j = 0; j < 2; j++) begin
               dv_r_ff[j][t+1]   <= ge_in[j]
                  ? fpts_pkg::D_W'(rs_in[j] - {1'b0, dv_d_ff[t]})
                  : fpts_pkg::D_W'(rs_in[j]);
               dv_q_ff[j][t+1]   <= {dv_q_ff[j][t][fpts_pkg::Q_W-2:0], ge_in[j]};
               dv_lo_ff[j][t+1]  <= dv_lo_ff[j][t] << 1;
               dv_ovf_ff[j][t+1] <= dv_ovf_ff[j][t];
               dv_neg_ff[j][t+1] <= dv_neg_ff[j][t];
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // final stage: saturate, apply sign, zero on kill
   logic [fpts_pkg::VAL_W-1:0] p_val_ff [2];
   logic                       p_sat_ff;
   logic [fpts_pkg::VAL_W-1:0] lim_in [2], mag_in [2], val_in [2];
   logic                       sat_in [2];

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         lim_in[j] = dv_neg_ff[j][fpts_pkg::Q_W] ? fpts_pkg::NEG_LIMIT : fpts_pkg::POS_LIMIT;
         sat_in[j] = !dv_kill_ff[fpts_pkg::Q_W]
                   && (dv_ovf_ff[j][fpts_pkg::Q_W]
                       || dv_q_ff[j][fpts_pkg::Q_W] > fpts_pkg::Q_W'(lim_in[j]));
         mag_in[j] = sat_in[j] ? lim_in[j]
                   : dv_q_ff[j][fpts_pkg::Q_W][fpts_pkg::VAL_W-1:0];
         if (dv_kill_ff[fpts_pkg::Q_W])
            val_in[j] = '0;
         else if (dv_neg_ff[j][fpts_pkg::Q_W])
            val_in[j] = ~mag_in[j] + 1'b1;
         else
            val_in[j] = mag_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_val_ff <= val_in;
         p_sat_ff <= sat_in[0] || sat_in[1];
      end
   end

   // ---------------------------------------------------------------
   // output register with skid behind it
   logic [fpts_pkg::VAL_W-1:0] o_re_ff, o_im_ff, sk_re_ff, sk_im_ff;
   logic                       o_sat_ff, sk_sat_ff;
   logic                       arrive;

   assign arrive = en && v_ff[fpts_pkg::NUM_ST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff  <= 1'b0;
         sk_v_ff <= 1'b0;
      end else if (take && sk_v_ff) begin
         o_v_ff  <= 1'b1;
         sk_v_ff <= 1'b0;
      end else if (arrive) begin
         if (!o_v_ff || take) o_v_ff <= 1'b1;
         else sk_v_ff <= 1'b1;
      end else if (take) begin
         o_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && sk_v_ff) begin
         o_re_ff  <= sk_re_ff;
         o_im_ff  <= sk_im_ff;
         o_sat_ff <= sk_sat_ff;
      end else if (arrive && (!o_v_ff || take)) begin
         o_re_ff  <= p_val_ff[0];
         o_im_ff  <= p_val_ff[1];
         o_sat_ff <= p_sat_ff;
      end
      if (arrive && o_v_ff && !take) begin
         sk_re_ff  <= p_val_ff[0];
         sk_im_ff  <= p_val_ff[1];
         sk_sat_ff <= p_sat_ff;
      end
   end

   assign rsp_valid     = o_v_ff;
   assign rsp_re_out    = o_re_ff;
   assign rsp_im_out    = o_im_ff;
   assign rsp_saturated = o_sat_ff;

endmodule

// ===== hdl/fpts_checker.sv =====
`include "fourier_potential_tidal_scale_unit_macros.svh"

module fpts_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [fpts_pkg::VAL_W-1:0] rsp_re_out,
   input logic signed [fpts_pkg::VAL_W-1:0] rsp_im_out,
   input logic                              rsp_saturated
);

   // a stalled response stays offered
   `FPTS_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "response dropped under stall")

   // a stalled response keeps its payload
   `FPTS_ASSERT_NXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_re_out) && $stable(rsp_im_out) && $stable(rsp_saturated), "response payload changed under stall")

   // a clipped response has a part at a bound
   `FPTS_ASSERT_NOW(a_sat_bound, rsp_valid && rsp_saturated, rsp_re_out == fpts_pkg::POS_LIMIT || rsp_re_out == fpts_pkg::NEG_LIMIT || rsp_im_out == fpts_pkg::POS_LIMIT || rsp_im_out == fpts_pkg::NEG_LIMIT, "saturated flag without clipped part")

   // requests are only held off while a response waits
   `FPTS_ASSERT_NOW(a_no_idle_stall, !rsp_valid, !req_stall, "request stalled with empty output")

endmodule

bind fourier_potential_tidal_scale_unit fpts_checker u_fpts_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_re_out    (rsp_re_out),
   .rsp_im_out    (rsp_im_out),
   .rsp_saturated (rsp_saturated)
);

// ===== bench/tb_fourier_potential_tidal_scale_unit.sv =====
`timescale 1ns / 100ps

module tb_fourier_potential_tidal_scale_unit;

   localparam int HANG_LIMIT  = 4000;   // cycles with no handshake at all
   localparam int DRAIN_TAIL  = 60;     // long enough to drain the pipeline

   typedef logic [255:0] wide_type;

   typedef struct packed {
      logic [fpts_pkg::IDX_W-1:0]        x_index;
      logic [fpts_pkg::IDX_W-1:0]        y_index;
      logic [fpts_pkg::IDX_W-1:0]        z_index;
      logic signed [fpts_pkg::VAL_W-1:0] re_in;
      logic signed [fpts_pkg::VAL_W-1:0] im_in;
   } bin_req_type;

   typedef struct packed {
      logic signed [fpts_pkg::VAL_W-1:0] re_out;
      logic signed [fpts_pkg::VAL_W-1:0] im_out;
      logic                              saturated;
   } bin_rsp_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [fpts_pkg::IDX_W-1:0] req_x_index, req_y_index, req_z_index;
   logic signed [fpts_pkg::VAL_W-1:0] req_re_in, req_im_in;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [fpts_pkg::VAL_W-1:0] rsp_re_out, rsp_im_out;
   logic rsp_saturated;
   logic csr_valid;
   logic csr_ready;
   logic [fpts_pkg::CSR_IX_W-1:0] csr_index;
   logic [fpts_pkg::STEP_W-1:0] csr_wdata;

   // register copies used by the predictor
   logic [fpts_pkg::GS_W-1:0]   grid_x, grid_y, grid_z;
   logic [fpts_pkg::STEP_W-1:0] step_x, step_y, step_z;
   logic [fpts_pkg::MODE_W-1:0] scale_mode;

   bin_rsp_type scaled_bins[$];
   int       error_count = 0;
   int       send_idle_pct = 0;
   int       recv_idle_pct = 0;
   int       idle_cycles = 0;
   int       bins_sent = 0;
   int       bins_checked = 0;
   int       sat_seen = 0;

   fourier_potential_tidal_scale_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_x_index(req_x_index), .req_y_index(req_y_index), .req_z_index(req_z_index),
      .req_re_in(req_re_in), .req_im_in(req_im_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_re_out(rsp_re_out), .rsp_im_out(rsp_im_out), .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint grid_cells(logic [fpts_pkg::GS_W-1:0] n);
      if (n < 2) return 2;
      if (n > fpts_pkg::MAX_GRID) return fpts_pkg::MAX_GRID;
      return longint'(n);
   endfunction

   // -1/k^2 or ka*kb/k^2 applied to one bin, rounded and clamped to Q16.16
   function automatic bin_rsp_type scale_bin(bin_req_type b);
      longint                      cells[3];
      longint                      wave[3];
      logic [fpts_pkg::STEP_W-1:0] steps[3];
      logic [63:0]                 kmag[3];
      bit                          kneg[3];
      wide_type                    sq;
      wide_type                    k2;
      wide_type                    base;
      wide_type                    num;
      wide_type                    quo;
      logic [fpts_pkg::VAL_W-1:0]  raw[2];
      logic [fpts_pkg::VAL_W-1:0]  vmag;
      logic [fpts_pkg::VAL_W-1:0]  lim;
      logic [fpts_pkg::VAL_W-1:0]  part[2];
      bit                          flip;
      bit                          neg;
      bit                          sat;
      int                          ax_a;
      int                          ax_b;
      bin_rsp_type                 r;

      cells[0] = grid_cells(grid_x);
      cells[1] = grid_cells(grid_y);
      cells[2] = grid_cells(grid_z);
      steps[0] = step_x;
      steps[1] = step_y;
      steps[2] = step_z;
      // x and y fold at half the grid; z only folds its Nyquist bin
      wave[0] = (2 * longint'(b.x_index) < cells[0]) ? longint'(b.x_index)
                                                    : longint'(b.x_index) - cells[0];
      wave[1] = (2 * longint'(b.y_index) < cells[1]) ? longint'(b.y_index)
                                                    : longint'(b.y_index) - cells[1];
      if (cells[2] % 2 == 0 && longint'(b.z_index) == cells[2] / 2)
         wave[2] = -(cells[2] / 2);
      else
         wave[2] = longint'(b.z_index);

      k2 = '0;
      for (int i = 0; i < 3; i++) begin
         kneg[i] = wave[i] < 0;
         kmag[i] = 64'(kneg[i] ? -wave[i] : wave[i]) * {32'd0, steps[i]};
         sq = wide_type'(kmag[i]);
         k2 = k2 + sq * sq;
      end
      r = '0;
      if (k2 == 0 || scale_mode == fpts_pkg::MODE_BAD) return r;

      case (scale_mode)
         fpts_pkg::MODE_XX: begin ax_a = 0; ax_b = 0; end
         fpts_pkg::MODE_XY: begin ax_a = 0; ax_b = 1; end
         fpts_pkg::MODE_XZ: begin ax_a = 0; ax_b = 2; end
         fpts_pkg::MODE_YY: begin ax_a = 1; ax_b = 1; end
         fpts_pkg::MODE_YZ: begin ax_a = 1; ax_b = 2; end
         default:           begin ax_a = 2; ax_b = 2; end
      endcase
      if (scale_mode == fpts_pkg::MODE_POT) begin
         base = wide_type'(1) << fpts_pkg::POT_SHIFT;
         flip = 1'b1;
      end else begin
         base = wide_type'(kmag[ax_a]);
         sq   = wide_type'(kmag[ax_b]);
         base = base * sq;
         flip = kneg[ax_a] ^ kneg[ax_b];
      end

      raw[0] = b.re_in;
      raw[1] = b.im_in;
      sat = 1'b0;
      for (int i = 0; i < 2; i++) begin
         vmag = raw[i][fpts_pkg::VAL_W-1] ? (32'd0 - raw[i]) : raw[i];
         sq   = wide_type'(vmag);
         num  = base * sq;
         neg  = (raw[i][fpts_pkg::VAL_W-1] != flip) && (num != 0);
         // round half away from zero on the magnitude
         quo  = (2 * num + k2) / (2 * k2);
         lim  = neg ? fpts_pkg::NEG_LIMIT : fpts_pkg::POS_LIMIT;
         if (quo > wide_type'(lim)) begin
            sat  = 1'b1;
            quo  = wide_type'(lim);
         end
         part[i] = neg ? (32'd0 - quo[fpts_pkg::VAL_W-1:0]) : quo[fpts_pkg::VAL_W-1:0];
      end
      r.re_out    = part[0];
      r.im_out    = part[1];
      r.saturated = sat;
      return r;
   endfunction

   // one request; expectation recorded at the accepting edge
   task automatic send_bin(bin_req_type b);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_x_index <= b.x_index;
      req_y_index <= b.y_index;
      req_z_index <= b.z_index;
      req_re_in   <= b.re_in;
      req_im_in   <= b.im_in;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      scaled_bins.push_back(scale_bin(b));
      bins_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (scaled_bins.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(fpts_pkg::csr_index_type ix, logic [fpts_pkg::STEP_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= ix;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (ix)
         fpts_pkg::CSR_GRID_X: grid_x = data[fpts_pkg::GS_W-1:0];
         fpts_pkg::CSR_GRID_Y: grid_y = data[fpts_pkg::GS_W-1:0];
         fpts_pkg::CSR_GRID_Z: grid_z = data[fpts_pkg::GS_W-1:0];
         fpts_pkg::CSR_STEP_X: step_x = data;
         fpts_pkg::CSR_STEP_Y: step_y = data;
         fpts_pkg::CSR_STEP_Z: step_z = data;
         default:              scale_mode = data[fpts_pkg::MODE_W-1:0];
      endcase
      @(posedge clock);
   endtask

   function automatic bin_req_type make_bin(int x, int y, int z, int re, int im);
      bin_req_type b;
      b.x_index = fpts_pkg::IDX_W'(x);
      b.y_index = fpts_pkg::IDX_W'(y);
      b.z_index = fpts_pkg::IDX_W'(z);
      b.re_in   = re;
      b.im_in   = im;
      return b;
   endfunction

   function automatic logic [fpts_pkg::VAL_W-1:0] random_value();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         1: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [fpts_pkg::STEP_W-1:0] random_step();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 255);
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(1 << 25, 1 << 29);
      endcase
   endfunction

   function automatic logic [fpts_pkg::STEP_W-1:0] random_grid();
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 1);
         1: return fpts_pkg::MAX_GRID;
         2: return $urandom_range(fpts_pkg::MAX_GRID + 1, 2047);
         3: return $urandom_range(2, 16);
         default: return $urandom_range(2, fpts_pkg::MAX_GRID);
      endcase
   endfunction

   // directed: reset defaults, zero bin, folding, Nyquist, value extremes
   task automatic test_default_grid();
      send_bin(make_bin(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
      send_bin(make_bin(1, 0, 0, 32'h0001_0000, -32'sh0001_0000));
      send_bin(make_bin(127, 128, 128, 32'h7FFF_FFFF, 32'h8000_0000));
      send_bin(make_bin(255, 1, 127, -1, 1));
      send_bin(make_bin(1023, 1023, 1023, 32'h1234_5678, 32'h8765_4321));
      send_bin(make_bin(0, 0, 512, 32'h8000_0000, 0));
      wait_idle();
   endtask

   // directed: every tidal component plus the unused mode code
   task automatic test_every_mode();
      write_csr(fpts_pkg::CSR_GRID_Z, 9);              // odd z: no Nyquist bin
      for (int m = fpts_pkg::MODE_XX; m <= fpts_pkg::MODE_BAD; m++) begin
         write_csr(fpts_pkg::CSR_MODE, m);
         send_bin(make_bin(3, 250, 4, 32'h0100_0000, -32'sh0300_0000));
         send_bin(make_bin(200, 5, 9, 32'h7FFF_FFFF, 32'h8000_0000));
         wait_idle();
      end
   endtask

   // directed: tiny and out-of-range grids, zero and huge steps
   task automatic test_grid_extremes();
      write_csr(fpts_pkg::CSR_MODE, fpts_pkg::MODE_POT);
      write_csr(fpts_pkg::CSR_GRID_X, 0);
      write_csr(fpts_pkg::CSR_GRID_Y, 2047);
      write_csr(fpts_pkg::CSR_GRID_Z, 1);
      write_csr(fpts_pkg::CSR_STEP_X, 1);
      write_csr(fpts_pkg::CSR_STEP_Y, 0);
      write_csr(fpts_pkg::CSR_STEP_Z, 32'hFFFF_FFFF);
      send_bin(make_bin(1, 700, 0, 32'h0000_0001, 32'h7FFF_FFFF));
      send_bin(make_bin(0, 3, 1, 32'h8000_0000, 32'h7FFF_FFFF));
      send_bin(make_bin(1023, 0, 0, 32'h0100_0000, -32'sh0100_0000));
      wait_idle();
   endtask

   task automatic randomize_csrs();
      write_csr(fpts_pkg::CSR_GRID_X, random_grid());
      write_csr(fpts_pkg::CSR_GRID_Y, random_grid());
      write_csr(fpts_pkg::CSR_GRID_Z, random_grid());
      write_csr(fpts_pkg::CSR_STEP_X, random_step());
      write_csr(fpts_pkg::CSR_STEP_Y, random_step());
      write_csr(fpts_pkg::CSR_STEP_Z, random_step());
      write_csr(fpts_pkg::CSR_MODE, $urandom_range(0, 7));
   endtask

   // random bins under random settings, one backpressure profile per pass
   task automatic test_random_bins(int send_pct, int recv_pct);
      bin_req_type b;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int s = 0; s < 4; s++) begin
         randomize_csrs();
         for (int i = 0; i < 90; i++) begin
            b.x_index = fpts_pkg::IDX_W'($urandom_range(0, 1023));
            b.y_index = fpts_pkg::IDX_W'($urandom_range(0, 1023));
            b.z_index = ($urandom_range(0, 7) == 0)
                      ? fpts_pkg::IDX_W'($urandom_range(0, 1023))
                      : fpts_pkg::IDX_W'($urandom_range(0, 512));
            b.re_in   = random_value();
            b.im_in   = random_value();
            send_bin(b);
         end
         wait_idle();
      end
   endtask

   // response check, receiver stalls and hang watchdog
   always @(posedge clock) begin
      bin_rsp_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= HANG_LIMIT) begin
            $display("no progress for %0d cycles", HANG_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (scaled_bins.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = scaled_bins.pop_front();
               bins_checked++;
               if (want.saturated) sat_seen++;
               if (rsp_re_out !== want.re_out) begin
                  $error("re_out expected %0d actual %0d", want.re_out, rsp_re_out);
                  error_count++;
               end
               if (rsp_im_out !== want.im_out) begin
                  $error("im_out expected %0d actual %0d", want.im_out, rsp_im_out);
                  error_count++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated expected %0b actual %0b", want.saturated,
                         rsp_saturated);
                  error_count++;
               end
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_x_index <= '0;
      req_y_index <= '0;
      req_z_index <= '0;
      req_re_in   <= '0;
      req_im_in   <= '0;
      rsp_stall   <= 1'b0;
      csr_valid   <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      grid_x = fpts_pkg::GS_W'(256);
      grid_y = fpts_pkg::GS_W'(256);
      grid_z = fpts_pkg::GS_W'(256);
      step_x = 32'h1000_0000;
      step_y = 32'h1000_0000;
      step_z = 32'h1000_0000;
      scale_mode = fpts_pkg::MODE_POT;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_grid();
      test_every_mode();
      test_grid_extremes();
      test_random_bins(10, 66);
      test_random_bins(66, 10);
      test_random_bins(0, 0);

      repeat (DRAIN_TAIL) @(posedge clock);
      if (scaled_bins.size() != 0) begin
         $error("%0d responses never arrived", scaled_bins.size());
         error_count++;
      end
      $display("Scaled %0d bins, checked %0d responses (%0d clipped) over all modes,",
               bins_sent, bins_checked, sat_seen);
      $display("grid sizes and steps, under three backpressure profiles.");
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
